### hw/rtl/esd_pkg.sv
// shared types and constants for the electron stopping drag block
`timescale 1ns / 1ps

package esd_pkg;

    localparam int COEFS_PER_TYPE = 5;

    // opcodes of an input beat
    localparam logic [1:0] OPC_LOAD = 2'd0;
    localparam logic [1:0] OPC_ATOM = 2'd1;
    localparam logic [1:0] OPC_STEP = 2'd2;

    // coefficient slots of one type
    localparam int CSEL_VMIN  = 0;
    localparam int CSEL_VMAX  = 1;
    localparam int CSEL_RSPAN = 2;
    localparam int CSEL_DRAG1 = 3;
    localparam int CSEL_DRAG2 = 4;

    localparam logic [62:0] MAX63 = {63{1'b1}};
    localparam logic signed [63:0] SMAX64 = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] SMIN64 = {1'b1, {63{1'b0}}};
    localparam logic [16:0] FRAC_ONE = 17'h10000;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DECODE, ST_RDC, ST_VV_M, ST_VV_W, ST_CHECK, ST_FR_M, ST_FR_W,
        ST_G_M, ST_G_W, ST_R_M, ST_R_W, ST_D_M, ST_D_W, ST_FO, ST_DSQ_M, ST_DSQ_W,
        ST_SV, ST_SV_W, ST_SD, ST_SD_W, ST_P_M, ST_P_W, ST_EMIT_A,
        ST_A_M, ST_A_W, ST_L_M, ST_L_W, ST_EMIT_S
    } t_state;

    typedef enum logic [4:0] {
        CMD_NOP, CMD_WRCOEF, CMD_RDC,
        CMD_MUL_VSQ, CMD_MUL_FR, CMD_MUL_G, CMD_MUL_RAMP, CMD_MUL_D, CMD_MUL_DSQ,
        CMD_MUL_PWR, CMD_MUL_A, CMD_MUL_LOSS,
        CMD_ACC_VV, CMD_SET_FR, CMD_SET_G, CMD_SET_GR, CMD_SET_D, CMD_SET_FO,
        CMD_ACC_SQ, CMD_ACC_PWR, CMD_SET_A, CMD_ACC_LOSS,
        CMD_SQRT_V, CMD_SQRT_D, CMD_SET_SV, CMD_SET_SD,
        CMD_EMIT_ATOM, CMD_EMIT_STEP
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op    op;
        logic [2:0] idx;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       type_ok;
        logic       active;
        logic       ramp;
        logic       mul_done;
        logic       sqrt_done;
    } t_dp_status;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] fx;
        logic signed [31:0] fy;
        logic signed [31:0] fz;
        logic               active;
        logic [62:0]        power;
        logic signed [63:0] loss;
    } t_result;

endpackage

### hw/rtl/esd_mul.sv
// 64x64 unsigned multiplier built from one 32x32 multiplier over four passes
`timescale 1ns / 1ps

module esd_mul import esd_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [63:0]  i_a,
    input  logic [63:0]  i_b,
    output logic         o_done,
    output logic [127:0] o_prod
);

    logic [63:0]  r_a, r_b;
    logic [127:0] r_p;
    logic [1:0]   r_cnt;
    logic         r_busy, r_done;
    logic [31:0]  a_h, b_h;
    logic [63:0]  pp;
    logic [1:0]   sh;

    always_comb begin
        a_h = r_cnt[0] ? r_a[63:32] : r_a[31:0];
        b_h = r_cnt[1] ? r_b[63:32] : r_b[31:0];
        pp  = 64'(a_h) * 64'(b_h);
        sh  = 2'(r_cnt[0]) + 2'(r_cnt[1]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_done <= r_busy && (r_cnt == 2'd3);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 2'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 2'd1;
                if (r_cnt == 2'd3) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
            r_p <= '0;
        end else if (r_busy) begin
            r_p <= r_p + (128'(pp) << {sh, 5'b0});
        end
    end

    assign o_done = r_done;
    assign o_prod = r_p;

endmodule

### hw/rtl/esd_sqrt.sv
// floor square root of a 64-bit value, one result bit per cycle
`timescale 1ns / 1ps

module esd_sqrt import esd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_x,
    output logic        o_done,
    output logic [31:0] o_root
);

    logic [63:0] r_rem, r_root, r_bit;
    logic [4:0]  r_cnt;
    logic        r_busy, r_done;
    logic [63:0] trial;

    assign trial = r_root + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == 5'd31);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_x;
            r_root <= '0;
            r_bit  <= 64'h4000_0000_0000_0000;
        end else if (r_busy) begin
            if (r_rem >= trial) begin
                r_rem  <= r_rem - trial;
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_root[31:0];

endmodule

### hw/rtl/esd_datapath.sv
// datapath: coefficient memory, shared multiplier, square root and accumulators
`timescale 1ns / 1ps

module esd_datapath import esd_pkg::*; #(
    parameter int NUM_TYPES = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_capture,
    input  logic [1:0]         i_opcode,
    input  logic [1:0]         i_atom_type,
    input  logic [2:0]         i_coef_select,
    input  logic signed [47:0] i_coef_value,
    input  logic signed [31:0] i_vel_x,
    input  logic signed [31:0] i_vel_y,
    input  logic signed [31:0] i_vel_z,
    input  logic signed [31:0] i_force_in_x,
    input  logic signed [31:0] i_force_in_y,
    input  logic signed [31:0] i_force_in_z,
    input  logic [15:0]        i_step_delta,
    input  logic [31:0]        i_time_step,
    input  t_cmd               i_cmd,
    output t_dp_status         o_status,
    output t_result            o_result
);

    localparam int DEPTH = NUM_TYPES * COEFS_PER_TYPE;
    localparam int AW    = $clog2(DEPTH);

    function automatic logic [63:0] mag64(input logic signed [63:0] x);
        logic [63:0] r;
        r = x[63] ? 64'(-x) : 64'(x);
        return r;
    endfunction

    // product >> 16, truncated toward zero, saturated to signed 64 bits
    function automatic logic signed [63:0] mulq(input logic [127:0] p, input logic neg);
        logic        ovf;
        logic [63:0] r;
        logic signed [63:0] q;
        ovf = (|p[127:80]) || p[79];
        r   = p[79:16];
        if (neg) begin
            q = ovf ? SMIN64 : -$signed(r);
        end else begin
            q = ovf ? SMAX64 : $signed(r);
        end
        return q;
    endfunction

    function automatic logic signed [63:0] satadd(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
        logic signed [64:0] s;
        logic signed [63:0] r;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            r = s[64] ? SMIN64 : SMAX64;
        end else begin
            r = s[63:0];
        end
        return r;
    endfunction

    logic signed [47:0] r_mem [DEPTH];
    logic signed [47:0] r_rdata;
    logic [AW-1:0]      wr_addr, rd_addr;
    logic [4:0]         wr_wide, rd_wide;

    logic [1:0]         r_op, r_typ;
    logic [2:0]         r_sel;
    logic signed [47:0] r_coef;
    logic signed [31:0] r_v [3];
    logic signed [31:0] r_f [3];
    logic signed [31:0] r_fo [3];
    logic [15:0]        r_sd;
    logic signed [47:0] r_c [COEFS_PER_TYPE];
    logic [63:0]        r_vv, r_sq;
    logic [16:0]        r_fr;
    logic signed [63:0] r_g, r_d;
    logic [31:0]        r_sv, r_sdr;
    logic [47:0]        r_a;
    logic [62:0]        r_cur, r_prior;
    logic signed [63:0] r_loss;
    logic               r_neg;

    logic               type_ok, active, ramp;
    logic signed [48:0] vv16_s;
    logic signed [49:0] diff;
    logic signed [31:0] v_k, f_k;
    logic               mul_start, mul_done, sqrt_start, sqrt_done;
    logic [63:0]        mul_a, mul_b, sqrt_x;
    logic               mul_neg;
    logic [127:0]       prod;
    logic [31:0]        root;
    logic signed [63:0] mq;
    logic [63:0]        dmag;
    logic [30:0]        dclamp;
    logic signed [65:0] fsum;
    logic [63:0]        pwr_sum;
    logic [62:0]        loss_term;

    assign type_ok = 32'(r_typ) < NUM_TYPES;
    assign vv16_s  = $signed({1'b0, r_vv[63:16]});
    assign active  = type_ok && (vv16_s > $signed({r_c[CSEL_VMIN][47], r_c[CSEL_VMIN]}));
    assign ramp    = vv16_s < $signed({r_c[CSEL_VMAX][47], r_c[CSEL_VMAX]});
    assign diff    = $signed({vv16_s[48], vv16_s})
                   - $signed({{2{r_c[CSEL_VMIN][47]}}, r_c[CSEL_VMIN]});
    assign v_k     = r_v[i_cmd.idx[1:0]];
    assign f_k     = r_f[i_cmd.idx[1:0]];
    assign mq      = mulq(prod, r_neg);
    assign dmag    = mag64(r_d);
    assign dclamp  = (dmag > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : dmag[30:0];

    // coefficient memory addressing
    assign wr_wide = 5'(r_typ) * 5'(COEFS_PER_TYPE) + 5'(r_sel);
    assign rd_wide = 5'(r_typ) * 5'(COEFS_PER_TYPE) + 5'(i_cmd.idx);
    assign wr_addr = AW'(wr_wide);
    assign rd_addr = AW'(rd_wide);

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == CMD_WRCOEF && type_ok && 32'(r_sel) < COEFS_PER_TYPE) begin
            r_mem[wr_addr] <= r_coef;
        end
        if (i_cmd.op == CMD_RDC && 32'(i_cmd.idx) < COEFS_PER_TYPE) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // operand selection for the shared multiplier
    always_comb begin
        mul_start = 1'b1;
        mul_a     = '0;
        mul_b     = '0;
        mul_neg   = 1'b0;
        case (i_cmd.op)
            CMD_MUL_VSQ: begin
                mul_a = mag64(64'(v_k));
                mul_b = mag64(64'(v_k));
            end
            CMD_MUL_FR: begin
                mul_a   = 64'(diff[48:0]);
                mul_b   = mag64(64'(r_c[CSEL_RSPAN]));
                mul_neg = r_c[CSEL_RSPAN][47];
            end
            CMD_MUL_G: begin
                mul_a   = mag64(64'(r_c[CSEL_DRAG2]));
                mul_b   = mag64(64'(v_k));
                mul_neg = r_c[CSEL_DRAG2][47] ^ v_k[31];
            end
            CMD_MUL_RAMP: begin
                mul_a   = 64'(r_fr);
                mul_b   = mag64(r_g);
                mul_neg = r_g[63];
            end
            CMD_MUL_D: begin
                mul_a   = mag64(r_g);
                mul_b   = mag64(64'(v_k));
                mul_neg = r_g[63] ^ v_k[31];
            end
            CMD_MUL_DSQ: begin
                mul_a = 64'(dclamp);
                mul_b = 64'(dclamp);
            end
            CMD_MUL_PWR: begin
                mul_a = 64'(r_sv);
                mul_b = 64'(r_sdr);
            end
            CMD_MUL_A: begin
                mul_a = 64'(r_sd);
                mul_b = 64'(i_time_step);
            end
            CMD_MUL_LOSS: begin
                mul_a = 64'(r_a);
                mul_b = 64'(r_prior) + 64'(r_cur);
            end
            default: mul_start = 1'b0;
        endcase
    end

    assign sqrt_start = (i_cmd.op == CMD_SQRT_V) || (i_cmd.op == CMD_SQRT_D);
    assign sqrt_x     = (i_cmd.op == CMD_SQRT_V) ? r_vv : r_sq;

    esd_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (prod)
    );

    esd_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_x     (sqrt_x),
        .o_done  (sqrt_done),
        .o_root  (root)
    );

    assign fsum      = 66'(f_k) - 66'(r_d);
    assign pwr_sum   = 64'(r_cur) + 64'(prod[63:16]);
    assign loss_term = (|prod[127:80]) ? MAX63 : prod[79:17];

    always_ff @(posedge i_clk) begin
        if (mul_start) begin
            r_neg <= mul_neg;
        end
        if (i_capture) begin
            r_op    <= i_opcode;
            r_typ   <= i_atom_type;
            r_sel   <= i_coef_select;
            r_coef  <= i_coef_value;
            r_v[0]  <= i_vel_x;
            r_v[1]  <= i_vel_y;
            r_v[2]  <= i_vel_z;
            r_f[0]  <= i_force_in_x;
            r_f[1]  <= i_force_in_y;
            r_f[2]  <= i_force_in_z;
            r_fo[0] <= i_force_in_x;
            r_fo[1] <= i_force_in_y;
            r_fo[2] <= i_force_in_z;
            r_sd    <= i_step_delta;
            r_vv    <= '0;
            r_sq    <= '0;
            r_d     <= '0;
        end
        case (i_cmd.op)
            CMD_RDC: begin
                if (i_cmd.idx != 3'd0) begin
                    r_c[i_cmd.idx - 3'd1] <= r_rdata;
                end
            end
            CMD_ACC_VV: r_vv <= r_vv + prod[63:0];
            CMD_SET_FR: begin
                if (mq[63]) begin
                    r_fr <= '0;
                end else if (mq > 64'(FRAC_ONE)) begin
                    r_fr <= FRAC_ONE;
                end else begin
                    r_fr <= mq[16:0];
                end
            end
            CMD_SET_G:  r_g <= satadd(mq, 64'(r_c[CSEL_DRAG1]));
            CMD_SET_GR: r_g <= mq;
            CMD_SET_D:  r_d <= mq;
            CMD_SET_FO: begin
                if (fsum > 66'sh7FFF_FFFF) begin
                    r_fo[i_cmd.idx[1:0]] <= 32'sh7FFF_FFFF;
                end else if (fsum < -66'sh8000_0000) begin
                    r_fo[i_cmd.idx[1:0]] <= 32'sh8000_0000;
                end else begin
                    r_fo[i_cmd.idx[1:0]] <= fsum[31:0];
                end
            end
            CMD_ACC_SQ: r_sq  <= r_sq + prod[63:0];
            CMD_SET_SV: r_sv  <= root;
            CMD_SET_SD: r_sdr <= root;
            CMD_SET_A:  r_a   <= prod[47:0];
            default: ;
        endcase
    end

    // architectural state with a defined reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur   <= '0;
            r_prior <= '0;
            r_loss  <= '0;
        end else begin
            case (i_cmd.op)
                CMD_ACC_PWR:   r_cur <= pwr_sum[63] ? MAX63 : pwr_sum[62:0];
                CMD_ACC_LOSS:  r_loss <= satadd(r_loss, $signed({1'b0, loss_term}));
                CMD_EMIT_STEP: begin
                    r_prior <= r_cur;
                    r_cur   <= '0;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        o_status.op        = r_op;
        o_status.type_ok   = type_ok;
        o_status.active    = active;
        o_status.ramp      = ramp;
        o_status.mul_done  = mul_done;
        o_status.sqrt_done = sqrt_done;

        o_result.power = r_cur;
        o_result.loss  = r_loss;
        if (i_cmd.op == CMD_EMIT_STEP) begin
            o_result.kind   = 1'b1;
            o_result.fx     = '0;
            o_result.fy     = '0;
            o_result.fz     = '0;
            o_result.active = 1'b0;
        end else begin
            o_result.kind   = 1'b0;
            o_result.fx     = r_fo[0];
            o_result.fy     = r_fo[1];
            o_result.fz     = r_fo[2];
            o_result.active = active;
        end
    end

endmodule

### hw/rtl/esd_ctrl.sv
// controller state machine that sequences the datapath
`timescale 1ns / 1ps

module esd_ctrl import esd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_out_free,
    input  t_dp_status i_status,
    output logic       o_in_stall,
    output logic       o_capture,
    output logic       o_out_load,
    output t_cmd       o_cmd
);

    t_state     r_state, n_state;
    logic [2:0] r_idx, n_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        o_cmd.op   = CMD_NOP;
        o_cmd.idx  = r_idx;
        o_capture  = 1'b0;
        o_out_load = 1'b0;
        o_in_stall = (r_state != ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_capture = 1'b1;
                    n_state   = ST_DECODE;
                end
            end
            ST_DECODE: begin
                n_idx = '0;
                unique case (i_status.op)
                    OPC_LOAD: begin
                        o_cmd.op = CMD_WRCOEF;
                        n_state  = ST_IDLE;
                    end
                    OPC_ATOM: n_state = i_status.type_ok ? ST_RDC : ST_EMIT_A;
                    OPC_STEP: n_state = ST_A_M;
                    default:  n_state = ST_IDLE;
                endcase
            end
            ST_RDC: begin
                o_cmd.op = CMD_RDC;
                if (32'(r_idx) == COEFS_PER_TYPE) begin
                    n_idx   = '0;
                    n_state = ST_VV_M;
                end else begin
                    n_idx = r_idx + 3'd1;
                end
            end
            ST_VV_M: begin
                o_cmd.op = CMD_MUL_VSQ;
                n_state  = ST_VV_W;
            end
            ST_VV_W: begin
                if (i_status.mul_done) begin
                    o_cmd.op = CMD_ACC_VV;
                    if (r_idx == 3'd2) begin
                        n_idx   = '0;
                        n_state = ST_CHECK;
                    end else begin
                        n_idx   = r_idx + 3'd1;
                        n_state = ST_VV_M;
                    end
                end
            end
            ST_CHECK: begin
                if (!i_status.active) begin
                    n_state = ST_EMIT_A;
                end else if (i_status.ramp) begin
                    n_state = ST_FR_M;
                end else begin
                    n_state = ST_G_M;
                end
            end
            ST_FR_M: begin
                o_cmd.op = CMD_MUL_FR;
                n_state  = ST_FR_W;
            end
            ST_FR_W: begin
                if (i_status.mul_done) begin
                    o_cmd.op = CMD_SET_FR;
                    n_state  = ST_G_M;
                end
            end
            ST_G_M: begin
                o_cmd.op = CMD_MUL_G;
                n_state  = ST_G_W;
            end
            ST_G_W: begin
                if (i_status.mul_done) begin
                    o_cmd.op = CMD_SET_G;
                    n_state  = i_status.ramp ? ST_R_M : ST_D_M;
                end
            end
            ST_R_M: begin
                o_cmd.op = CMD_MUL_RAMP;
                n_state  = ST_R_W;
            end
            ST_R_W: begin
                if (i_status.mul_done) begin
                    o_cmd.op = CMD_SET_GR;
                    n_state  = ST_D_M;
                end
            end
            ST_D_M: begin
                o_cmd.op = CMD_MUL_D;
                n_state  = ST_D_W;
            end
            ST_D_W: begin
                if (i_status.mul_done) begin
                    o_cmd.op = CMD_SET_D;
                    n_state  = ST_FO;
                end
            end
            ST_FO: begin
                o_cmd.op = CMD_SET_FO;
                n_state  = ST_DSQ_M;
            end
            ST_DSQ_M: begin
                o_cmd.op = CMD_MUL_DSQ;
                n_state  = ST_DSQ_W;
            end
            ST_DSQ_W: begin
                if (i_status.mul_done) begin
                    o_cmd.op = CMD_ACC_SQ;
                    if (r_idx == 3'd2) begin
                        n_idx   = '0;
                        n_state = ST_SV;
                    end else begin
                        n_idx   = r_idx + 3'd1;
                        n_state = ST_G_M;
                    end
                end
            end
            ST_SV: begin
                o_cmd.op = CMD_SQRT_V;
                n_state  = ST_SV_W;
            end
            ST_SV_W: begin
                if (i_status.sqrt_done) begin
                    o_cmd.op = CMD_SET_SV;
                    n_state  = ST_SD;
                end
            end
            ST_SD: begin
                o_cmd.op = CMD_SQRT_D;
                n_state  = ST_SD_W;
            end
            ST_SD_W: begin
                if (i_status.sqrt_done) begin
                    o_cmd.op = CMD_SET_SD;
                    n_state  = ST_P_M;
                end
            end
            ST_P_M: begin
                o_cmd.op = CMD_MUL_PWR;
                n_state  = ST_P_W;
            end
            ST_P_W: begin
                if (i_status.mul_done) begin
                    o_cmd.op = CMD_ACC_PWR;
                    n_state  = ST_EMIT_A;
                end
            end
            ST_EMIT_A: begin
                if (i_out_free) begin
                    o_cmd.op   = CMD_EMIT_ATOM;
                    o_out_load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            ST_A_M: begin
                o_cmd.op = CMD_MUL_A;
                n_state  = ST_A_W;
            end
            ST_A_W: begin
                if (i_status.mul_done) begin
                    o_cmd.op = CMD_SET_A;
                    n_state  = ST_L_M;
                end
            end
            ST_L_M: begin
                o_cmd.op = CMD_MUL_LOSS;
                n_state  = ST_L_W;
            end
            ST_L_W: begin
                if (i_status.mul_done) begin
                    o_cmd.op = CMD_ACC_LOSS;
                    n_state  = ST_EMIT_S;
                end
            end
            ST_EMIT_S: begin
                if (i_out_free) begin
                    o_cmd.op   = CMD_EMIT_STEP;
                    o_out_load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

### hw/rtl/electron_stopping_drag.sv
// top level of the electron stopping drag block: control port, sequencer, datapath, output beat
`timescale 1ns / 1ps
// result beat for every end of step and every atom: of unknown type, below threshold, active,
//   or active with the ramp; a coefficient load gives none
// flow: one beat at a time, the next beat taken once the result is in the output register (a
//   load gives no result); paced by the shared multiplier (four 32x32 passes per product) and the
//   32-step square root run twice per active atom
// reset: synchronous active low; power and loss totals clear, time step returns to 1.0.

module electron_stopping_drag import esd_pkg::*; #(
    parameter int NUM_TYPES = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [1:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_opcode,
    input  logic [1:0]         i_atom_type,
    input  logic [2:0]         i_coef_select,
    input  logic signed [47:0] i_coef_value,
    input  logic signed [31:0] i_vel_x,
    input  logic signed [31:0] i_vel_y,
    input  logic signed [31:0] i_vel_z,
    input  logic signed [31:0] i_force_in_x,
    input  logic signed [31:0] i_force_in_y,
    input  logic signed [31:0] i_force_in_z,
    input  logic [15:0]        i_step_delta,
    // output channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_result_kind,
    output logic signed [31:0] o_force_out_x,
    output logic signed [31:0] o_force_out_y,
    output logic signed [31:0] o_force_out_z,
    output logic               o_drag_active,
    output logic [62:0]        o_step_power,
    output logic signed [63:0] o_energy_loss
);

    // the coefficient table holds no defined value until it is loaded

    localparam logic [1:0]  ADDR_TIME_STEP  = 2'd0;
    localparam logic [31:0] TIME_STEP_RESET = 32'h0001_0000;

    logic [31:0] r_time_step;
    logic        cfg_write;

    t_cmd       cmd;
    t_dp_status status;
    t_result    result;
    t_result    r_out;
    logic       r_out_valid;
    logic       capture, out_load, out_free;

    // control register: no wait states, single time step register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr == ADDR_TIME_STEP) ? r_time_step : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step <= TIME_STEP_RESET;
        end else if (cfg_write && paddr == ADDR_TIME_STEP) begin
            r_time_step <= pwdata;
        end
    end

    // the sequencer owns the input handshake and decides when a result is formed
    esd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_free (out_free),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_capture  (capture),
        .o_out_load (out_load),
        .o_cmd      (cmd)
    );

    esd_datapath #(
        .NUM_TYPES (NUM_TYPES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_capture     (capture),
        .i_opcode      (i_opcode),
        .i_atom_type   (i_atom_type),
        .i_coef_select (i_coef_select),
        .i_coef_value  (i_coef_value),
        .i_vel_x       (i_vel_x),
        .i_vel_y       (i_vel_y),
        .i_vel_z       (i_vel_z),
        .i_force_in_x  (i_force_in_x),
        .i_force_in_y  (i_force_in_y),
        .i_force_in_z  (i_force_in_z),
        .i_step_delta  (i_step_delta),
        .i_time_step   (r_time_step),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_result      (result)
    );

    // output register: a finished beat waits here while the next item is taken in
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_result_kind = r_out.kind;
    assign o_force_out_x = r_out.fx;
    assign o_force_out_y = r_out.fy;
    assign o_force_out_z = r_out.fz;
    assign o_drag_active = r_out.active;
    assign o_step_power  = r_out.power;
    assign o_energy_loss = r_out.loss;

    // a waiting result beat is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !out_load)
        else $error("result beat overwritten while stalled");

    // an accepted item keeps the input stalled while it is worked on
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while previous item in flight");

    // a step summary carries no drag
    a_summary_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_result_kind) |-> (!o_drag_active && o_force_out_x == 32'sd0
            && o_force_out_y == 32'sd0 && o_force_out_z == 32'sd0))
        else $error("step summary with drag fields set");

endmodule

### tb/electron_stopping_drag_test.sv
// self-checking testbench for the electron stopping drag block
`timescale 1ns / 1ps

module electron_stopping_drag_test;
    import esd_pkg::*;

    localparam int  NTYPES      = 4;
    localparam int  CYCLE_LIMIT = 3000000;
    localparam int  DRAIN       = 300;
    localparam logic [1:0] OPC_BAD  = 2'd3;
    localparam logic [1:0] ADDR_TSTEP = 2'd0;
    localparam logic [63:0] POW_MAX = {1'b0, {63{1'b1}}};

    // one input beat as it goes on the wire
    typedef struct {
        logic [1:0]         opcode;
        logic [1:0]         atype;
        logic [2:0]         csel;
        logic signed [47:0] cval;
        logic signed [31:0] vel [3];
        logic signed [31:0] frc [3];
        logic [15:0]        sdelta;
    } t_beat;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        o_in_stall;
    logic        out_stall = 1'b0;
    logic        o_out_valid;
    logic        o_result_kind, o_drag_active;
    logic signed [31:0] o_force_out_x, o_force_out_y, o_force_out_z;
    logic [62:0]        o_step_power;
    logic signed [63:0] o_energy_loss;

    t_beat   cur_beat;
    t_beat   beat_queue [$];
    t_result result_queue [$];

    // predictor state
    logic signed [63:0] coef_mem [NTYPES*COEFS_PER_TYPE];
    logic [63:0]        cur_power, prev_power;
    logic signed [63:0] loss_sum;
    logic [31:0]        tstep;

    int  cycles = 0;
    int  fails = 0;
    int  hold_cnt = 0;

    electron_stopping_drag #(.NUM_TYPES(NTYPES)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_in_valid(in_valid), .o_in_stall(o_in_stall),
        .i_opcode(cur_beat.opcode), .i_atom_type(cur_beat.atype),
        .i_coef_select(cur_beat.csel), .i_coef_value(cur_beat.cval),
        .i_vel_x(cur_beat.vel[0]), .i_vel_y(cur_beat.vel[1]), .i_vel_z(cur_beat.vel[2]),
        .i_force_in_x(cur_beat.frc[0]), .i_force_in_y(cur_beat.frc[1]),
        .i_force_in_z(cur_beat.frc[2]), .i_step_delta(cur_beat.sdelta),
        .o_out_valid(o_out_valid), .i_out_stall(out_stall),
        .o_result_kind(o_result_kind), .o_force_out_x(o_force_out_x),
        .o_force_out_y(o_force_out_y), .o_force_out_z(o_force_out_z),
        .o_drag_active(o_drag_active), .o_step_power(o_step_power),
        .o_energy_loss(o_energy_loss)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ---------------- fixed-point helpers ----------------

    // signed q16 product, truncated toward zero, saturated to 64 bits
    function automatic logic signed [63:0] q16_mul(logic signed [63:0] a, logic signed [63:0] b);
        logic [63:0]  ma, mb;
        logic [127:0] p;
        logic         neg;
        neg = (a < 0) != (b < 0);
        ma  = (a < 0) ? -a : a;
        mb  = (b < 0) ? -b : b;
        p   = ({64'd0, ma} * {64'd0, mb}) >> 16;
        if (neg) begin
            if (p >= 128'h8000_0000_0000_0000) return SMIN64;
            return -$signed(p[63:0]);
        end
        if (p > {64'd0, POW_MAX}) return SMAX64;
        return $signed(p[63:0]);
    endfunction

    function automatic logic signed [63:0] sat_add(logic signed [63:0] a, logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s > $signed({1'b0, SMAX64})) return SMAX64;
        if (s < $signed({1'b1, SMIN64})) return SMIN64;
        return s[63:0];
    endfunction

    // floor square root, bit by bit
    function automatic logic [63:0] floor_sqrt(logic [63:0] x);
        logic [63:0] r, bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= r + bitv) begin
                x = x - (r + bitv);
                r = (r >> 1) + bitv;
            end else begin
                r = r >> 1;
            end
            bitv = bitv >> 2;
        end
        return r;
    endfunction

    // ---------------- predictor ----------------

    // updates the drag state for one accepted beat and queues the result it causes
    task automatic predict_drag(input t_beat b);
        t_result            res;
        logic signed [63:0] dforce [3];
        logic signed [63:0] c [COEFS_PER_TYPE];
        logic signed [63:0] vv16, g, fr, nd, fo;
        logic [63:0]        vv, m, sq, term, a, s;
        logic [127:0]       prod;
        int                 base;
        res = '0;
        case (b.opcode)
            OPC_LOAD: begin
                if (b.csel < COEFS_PER_TYPE && b.atype < NTYPES)
                    coef_mem[b.atype*COEFS_PER_TYPE + b.csel] = 64'(b.cval);
            end
            OPC_ATOM: begin
                vv = 0;
                for (int k = 0; k < 3; k++) begin
                    dforce[k] = 0;
                    m  = (b.vel[k] < 0) ? -64'(b.vel[k]) : 64'(b.vel[k]);
                    vv = vv + m * m;
                end
                if (b.atype < NTYPES) begin
                    base = b.atype * COEFS_PER_TYPE;
                    for (int k = 0; k < COEFS_PER_TYPE; k++) c[k] = coef_mem[base + k];
                    vv16 = $signed(vv >> 16);
                    if (vv16 > c[CSEL_VMIN]) begin
                        res.active = 1'b1;
                        sq = 0;
                        for (int k = 0; k < 3; k++) begin
                            g = sat_add(q16_mul(c[CSEL_DRAG2], 64'(b.vel[k])), c[CSEL_DRAG1]);
                            // ramp region between the two thresholds
                            if (vv16 < c[CSEL_VMAX]) begin
                                fr = q16_mul(vv16 - c[CSEL_VMIN], c[CSEL_RSPAN]);
                                if (fr < 0) fr = 0;
                                if (fr > 65536) fr = 65536;
                                g = q16_mul(fr, g);
                            end
                            dforce[k] = q16_mul(g, 64'(b.vel[k]));
                        end
                        for (int k = 0; k < 3; k++) begin
                            m = (dforce[k] < 0) ? -dforce[k] : dforce[k];
                            if (m > 64'h7FFF_FFFF) m = 64'h7FFF_FFFF;
                            sq = sq + m * m;
                        end
                        term = (floor_sqrt(vv) * floor_sqrt(sq)) >> 16;
                        cur_power = cur_power + term;   // 64-bit wrap, then clamp
                        if (cur_power > POW_MAX) cur_power = POW_MAX;
                    end
                end
                for (int k = 0; k < 3; k++) begin
                    nd = (dforce[k] == SMIN64) ? SMAX64 : -dforce[k];
                    fo = sat_add(64'(b.frc[k]), nd);
                    if (fo > 64'sh7FFF_FFFF) fo = 64'sh7FFF_FFFF;
                    if (fo < -64'sh8000_0000) fo = -64'sh8000_0000;
                    if (k == 0) res.fx = fo[31:0];
                    if (k == 1) res.fy = fo[31:0];
                    if (k == 2) res.fz = fo[31:0];
                end
                res.kind  = 1'b0;
                res.power = cur_power[62:0];
                res.loss  = loss_sum;
                result_queue.push_back(res);
            end
            OPC_STEP: begin
                a    = 64'(b.sdelta) * 64'(tstep);
                s    = prev_power + cur_power;
                prod = ({64'd0, a} * {64'd0, s}) >> 17;
                if (prod > {64'd0, POW_MAX}) prod = {64'd0, POW_MAX};
                loss_sum   = sat_add(loss_sum, $signed(prod[63:0]));
                res.kind   = 1'b1;
                res.power  = cur_power[62:0];
                res.loss   = loss_sum;
                prev_power = cur_power;
                cur_power  = 0;
                result_queue.push_back(res);
            end
            default: ;  // unknown opcode is dropped
        endcase
    endtask

    // ---------------- stimulus helpers ----------------

    function automatic logic [47:0] rand48();
        return 48'({$urandom(), $urandom()});
    endfunction

    function automatic t_beat blank_beat(logic [1:0] opc);
        t_beat b;
        b.opcode = opc;
        b.atype  = 2'($urandom_range(NTYPES - 1));
        b.csel   = '0;
        b.cval   = '0;
        for (int k = 0; k < 3; k++) begin
            b.vel[k] = '0;
            b.frc[k] = $urandom();
        end
        b.sdelta = '0;
        return b;
    endfunction

    // coefficient load, mostly with values that give a mix of idle, ramp and full drag
    function automatic t_beat coef_beat(logic [1:0] typ, logic [2:0] sel);
        t_beat b;
        b = blank_beat(OPC_LOAD);
        b.atype = typ;
        b.csel  = sel;
        if ($urandom_range(9) == 0) begin
            b.cval = rand48();
        end else begin
            case (sel)
                CSEL_VMIN:  b.cval = 48'($urandom_range(1 << 20));
                CSEL_VMAX:  b.cval = 48'($urandom_range(1 << 21));
                CSEL_RSPAN: b.cval = 48'($urandom_range(1 << 17));
                default:    b.cval = 48'($signed($urandom_range(1 << 18)) - (1 << 17));
            endcase
        end
        return b;
    endfunction

    function automatic t_beat atom_beat();
        t_beat b;
        b = blank_beat(OPC_ATOM);
        for (int k = 0; k < 3; k++) begin
            if ($urandom_range(7) == 0) b.vel[k] = $urandom();
            else b.vel[k] = $signed($urandom_range(1 << 19)) - (1 << 18);
        end
        return b;
    endfunction

    function automatic t_beat step_beat();
        t_beat b;
        b = blank_beat(OPC_STEP);
        b.sdelta = ($urandom_range(3) == 0) ? 16'($urandom()) : 16'($urandom_range(4));
        return b;
    endfunction

    function automatic t_beat random_beat();
        t_beat b;
        int    pick;
        pick = $urandom_range(99);
        if (pick < 68)      b = atom_beat();
        else if (pick < 80) b = step_beat();
        else if (pick < 94) begin
            b = coef_beat(2'($urandom_range(NTYPES - 1)), 3'($urandom_range(4)));
        end else if (pick < 97) begin
            // noise: a load to a reserved slot here, an unknown opcode in the branch below
            b = coef_beat(2'($urandom_range(NTYPES - 1)), 3'($urandom_range(7, 5)));
        end else begin
            b = atom_beat();
            b.opcode = OPC_BAD;
            b.sdelta = 16'($urandom());
            b.cval   = rand48();
        end
        return b;
    endfunction

    // idle about 38 percent of the time, never inside the quiet window
    function automatic logic take_gap();
        if (cycles > 40000 && cycles < 90000) return 1'b0;
        return $urandom_range(99) < 38;
    endfunction

    task automatic write_tstep(input logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_TSTEP;
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tstep = val;
    endtask

    task automatic wait_quiet();
        while (beat_queue.size() != 0 || in_valid || result_queue.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    // ---------------- sender ----------------

    // the predictor runs on the beat as it is taken; the next beat goes out in the same edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall) predict_drag(cur_beat);
            if (!in_valid || !o_in_stall) begin
                if (beat_queue.size() != 0 && !take_gap()) begin
                    in_valid <= 1'b1;
                    cur_beat <= beat_queue.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- receiver ----------------

    // long hold-off once, so the block backs up into the input
    always @(posedge i_clk) begin
        if (cycles == 20000) hold_cnt <= 4000;
        else if (hold_cnt != 0) hold_cnt <= hold_cnt - 1;
    end

    always @(posedge i_clk) begin
        out_stall <= (hold_cnt > 1) || take_gap();
    end

    // compare each result beat against the oldest prediction
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (result_queue.size() == 0) begin
                $error("unexpected result beat: kind %0d", o_result_kind);
                fails++;
            end else begin
                want = result_queue.pop_front();
                if (o_result_kind !== want.kind) begin
                    $error("result_kind: expected %0d, got %0d", want.kind, o_result_kind);
                    fails++;
                end
                if (o_force_out_x !== want.fx) begin
                    $error("force_out_x: expected %0d, got %0d", want.fx, o_force_out_x);
                    fails++;
                end
                if (o_force_out_y !== want.fy) begin
                    $error("force_out_y: expected %0d, got %0d", want.fy, o_force_out_y);
                    fails++;
                end
                if (o_force_out_z !== want.fz) begin
                    $error("force_out_z: expected %0d, got %0d", want.fz, o_force_out_z);
                    fails++;
                end
                if (o_drag_active !== want.active) begin
                    $error("drag_active: expected %0d, got %0d", want.active, o_drag_active);
                    fails++;
                end
                if (o_step_power !== want.power) begin
                    $error("step_power: expected %0d, got %0d", want.power, o_step_power);
                    fails++;
                end
                if (o_energy_loss !== want.loss) begin
                    $error("energy_loss: expected %0d, got %0d", want.loss, o_energy_loss);
                    fails++;
                end
            end
        end
    end

    // run watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("electron_stopping_drag_test: FAIL");
            $finish;
        end
    end

    // ---------------- sequence ----------------

    initial begin
        logic [31:0] tsteps [5];
        t_beat       b;
        cur_beat  = blank_beat(OPC_BAD);
        cur_power = 0;
        prev_power = 0;
        loss_sum  = 0;
        tstep     = 32'h0001_0000;
        for (int i = 0; i < NTYPES*COEFS_PER_TYPE; i++) coef_mem[i] = 0;
        tsteps = '{32'h0001_0000, 32'h0, 32'hFFFF_FFFF, $urandom(), 32'($urandom_range(1 << 18))};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < 5; ph++) begin
            write_tstep(tsteps[ph]);
            if (ph == 0) begin
                // directed: fill every table slot first
                for (int t = 0; t < NTYPES; t++)
                    for (int s = 0; s < COEFS_PER_TYPE; s++)
                        beat_queue.push_back(coef_beat(2'(t), 3'(s)));
                b = atom_beat();          // zero speed, idle unless the threshold is negative
                for (int k = 0; k < 3; k++) b.vel[k] = 0;
                beat_queue.push_back(b);
                b = atom_beat();          // most negative velocity and force
                for (int k = 0; k < 3; k++) begin
                    b.vel[k] = 32'h8000_0000;
                    b.frc[k] = 32'h8000_0000;
                end
                beat_queue.push_back(b);
                b = atom_beat();          // largest velocity and force
                for (int k = 0; k < 3; k++) begin
                    b.vel[k] = 32'h7FFF_FFFF;
                    b.frc[k] = 32'h7FFF_FFFF;
                end
                beat_queue.push_back(b);
                b = step_beat();          // longest step gap
                b.sdelta = 16'hFFFF;
                beat_queue.push_back(b);
                b = random_beat();        // unknown opcode
                b.opcode = OPC_BAD;
                beat_queue.push_back(b);
                beat_queue.push_back(coef_beat(2'd0, 3'd7));  // reserved slot
            end
            for (int n = 0; n < 310; n++) beat_queue.push_back(random_beat());
            wait_quiet();
        end

        if (fails == 0) begin
            $display("electron_stopping_drag_test: PASS");
        end else begin
            $display("electron_stopping_drag_test: FAIL");
        end
        $finish;
    end

endmodule

### sim.f
hw/rtl/esd_pkg.sv
hw/rtl/esd_mul.sv
hw/rtl/esd_sqrt.sv
hw/rtl/esd_datapath.sv
hw/rtl/esd_ctrl.sv
hw/rtl/electron_stopping_drag.sv
tb/electron_stopping_drag_test.sv
